>>> design/ptob_pkg.sv
// ----------------------------------------------------------------------------
// ptob_pkg
// Shared types and constants of the price-time order book.
// ----------------------------------------------------------------------------
package ptob_pkg;

    localparam int ORDER_SLOTS = 32;
    localparam int SLOT_W      = $clog2(ORDER_SLOTS);
    localparam int MAX_FILLS   = 32;
    localparam int FILL_W      = $clog2(MAX_FILLS + 1);
    localparam int IN_DATA_W   = 128;
    localparam int OUT_DATA_W  = 232;

    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_CANCEL = 1'b1;
    localparam logic SIDE_BUY    = 1'b0;
    localparam logic SIDE_SELL   = 1'b1;
    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_FINAL  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_SCAN,
        S_DECIDE,
        S_FILL,
        S_EMIT_TRADE,
        S_EMIT_FINAL
    } state_t;

    typedef struct packed {
        logic load;
        logic lookup;
        logic scan;
        logic fill;
        logic emit_trade;
        logic emit_final;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic can_fill;
        logic out_free;
    } stat_t;

endpackage

>>> design/price_time_order_book.sv
// ----------------------------------------------------------------------------
// price_time_order_book
// Price-time priority limit order book over a fixed table of resting orders.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Every transaction runs a lookup
// step, then a full scan of the slot table (one slot per cycle) that finds
// the best bid and best ask, then its completion result. In a market add,
// every fill is followed by a rescan of the table, and output backpressure
// can stall the emission of each result. Each trade result precedes the
// single completion result, which carries tlast.
module price_time_order_book (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // id[63:0], price[95:64], quantity[127:96]
    input  logic [ptob_pkg::IN_DATA_W-1:0]    s_tdata,
    // func[0], side[1], is_market[2]
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], resting_id[65:2], trade_price[97:66], trade_qty[129:98],
    // unfilled_qty[161:130], best_bid[193:162], bid_valid[194],
    // best_ask[226:195], ask_valid[227], zero pad
    output logic [ptob_pkg::OUT_DATA_W-1:0]   m_tdata,
    // kind[0]
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast
);
    import ptob_pkg::*;

    cmd_t  cmd;
    stat_t st;

    ptob_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ptob_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

>>> design/ptob_ctrl.sv
// ----------------------------------------------------------------------------
// ptob_ctrl
// Sequencer of the order book: lookup, book scans, fills and result emission.
// ----------------------------------------------------------------------------
module ptob_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ptob_pkg::stat_t st,
    output ptob_pkg::cmd_t  cmd
);
    import ptob_pkg::*;

    state_t state_reg, state_next;
    logic   pend_reg, pend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                pend_next  = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (pend_reg)
                    state_next = S_EMIT_TRADE;
                else if (st.can_fill)
                    state_next = S_FILL;
                else
                    state_next = S_EMIT_FINAL;
            end
            S_FILL:
            begin
                cmd.fill   = 1'b1;
                pend_next  = 1'b1;
                state_next = S_SCAN;
            end
            S_EMIT_TRADE:
            begin
                if (st.out_free)
                begin
                    cmd.emit_trade = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = S_DECIDE;
                end
            end
            S_EMIT_FINAL:
            begin
                if (st.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_fill_allowed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> $past(st.can_fill))
        else $error("fill issued without a fillable order");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_trade || cmd.emit_final) |-> st.out_free)
        else $error("result loaded into a busy output register");
    a_fill_rescan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |=> state_reg == S_SCAN && pend_reg)
        else $error("fill not followed by a book scan");
`endif

endmodule

>>> design/ptob_dp.sv
// ----------------------------------------------------------------------------
// ptob_dp
// Order book datapath: slot table, id lookup, best-price scan, fill unit and
// output register.
// ----------------------------------------------------------------------------
module ptob_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ptob_pkg::IN_DATA_W-1:0]   in_data,
    input  logic [2:0]                       in_user,
    input  ptob_pkg::cmd_t                   cmd,
    output ptob_pkg::stat_t                  st,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ptob_pkg::OUT_DATA_W-1:0]  out_data,
    output logic [0:0]                       out_user,
    output logic                             out_last
);
    import ptob_pkg::*;

    // input item
    logic        func_reg, side_reg, mkt_reg;
    logic [63:0] id_reg;
    logic [31:0] price_reg, qty_reg;

    // slot table
    logic [ORDER_SLOTS-1:0] valid_reg;
    logic [63:0] sid_reg   [ORDER_SLOTS];
    logic        sside_reg [ORDER_SLOTS];
    logic [31:0] sprice_reg[ORDER_SLOTS];
    logic [31:0] srem_reg  [ORDER_SLOTS];
    logic [31:0] sseq_reg  [ORDER_SLOTS];
    logic [31:0] arrival_reg;

    // operation state
    status_t     status_reg;
    logic        match_reg;
    logic [31:0] left_reg;
    logic [FILL_W-1:0] fills_reg;
    logic [63:0] tid_reg;
    logic [31:0] tprice_reg, tqty_reg;

    // scan trackers
    logic [SLOT_W-1:0] scan_reg;
    logic        bv_reg, av_reg;
    logic [31:0] bp_reg, ap_reg, bage_reg, aage_reg;
    logic [SLOT_W-1:0] bi_reg, ai_reg;

    // output register
    logic                  ovalid_reg;
    logic [OUT_DATA_W-1:0] odata_reg;
    logic                  okind_reg;

    // lookup
    logic [ORDER_SLOTS-1:0] hit_vec;
    logic                   hit_any, free_any;
    logic [SLOT_W-1:0]      hit_idx, free_idx;

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < ORDER_SLOTS; i++)
            hit_vec[i] = valid_reg[i] && (sid_reg[i] == id_reg);
        for (int i = ORDER_SLOTS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
                hit_idx = SLOT_W'(i);
            if (!valid_reg[i])
                free_idx = SLOT_W'(i);
        end
        hit_any  = |hit_vec;
        free_any = ~&valid_reg;
    end

    // scan step
    logic        c_valid, c_side, first, b_better, a_better, scan_last;
    logic [31:0] c_price, c_age;

    always_comb
    begin
        c_valid   = valid_reg[scan_reg];
        c_side    = sside_reg[scan_reg];
        c_price   = sprice_reg[scan_reg];
        c_age     = arrival_reg - sseq_reg[scan_reg];
        first     = (scan_reg == '0);
        scan_last = (scan_reg == SLOT_W'(ORDER_SLOTS - 1));
        b_better  = first || !bv_reg ||
                    ((c_price != bp_reg) ? (c_price > bp_reg) : (c_age > bage_reg));
        a_better  = first || !av_reg ||
                    ((c_price != ap_reg) ? (c_price < ap_reg) : (c_age > aage_reg));
    end

    // fill
    logic              opp_vld;
    logic [SLOT_W-1:0] opp_idx;
    logic [31:0]       opp_rem, ex_qty;

    always_comb
    begin
        opp_vld = side_reg ? bv_reg : av_reg;
        opp_idx = side_reg ? bi_reg : ai_reg;
        opp_rem = srem_reg[opp_idx];
        ex_qty  = (left_reg < opp_rem) ? left_reg : opp_rem;
    end

    assign st.scan_last = scan_last;
    assign st.can_fill  = match_reg && (left_reg != '0) && opp_vld &&
                          (fills_reg < FILL_W'(MAX_FILLS));
    assign st.out_free  = !ovalid_reg || out_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            arrival_reg <= '0;
            scan_reg    <= '0;
            ovalid_reg  <= 1'b0;
            match_reg   <= 1'b0;
            fills_reg   <= '0;
            bv_reg      <= 1'b0;
            av_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.lookup)
            begin
                match_reg <= 1'b0;
                fills_reg <= '0;
                if (func_reg == FUNC_CANCEL)
                begin
                    if (hit_any)
                        valid_reg[hit_idx] <= 1'b0;
                end
                else if (!hit_any)
                begin
                    if (mkt_reg)
                        match_reg <= 1'b1;
                    else if (qty_reg != '0 && free_any)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        arrival_reg         <= arrival_reg + 32'd1;
                    end
                end
            end
            if (cmd.scan)
            begin
                scan_reg <= scan_last ? '0 : scan_reg + SLOT_W'(1);
                if (c_valid && c_side == SIDE_BUY && b_better)
                    bv_reg <= 1'b1;
                else if (first)
                    bv_reg <= 1'b0;
                if (c_valid && c_side == SIDE_SELL && a_better)
                    av_reg <= 1'b1;
                else if (first)
                    av_reg <= 1'b0;
            end
            if (cmd.fill)
            begin
                fills_reg <= fills_reg + FILL_W'(1);
                if (opp_rem == ex_qty)
                    valid_reg[opp_idx] <= 1'b0;
            end
            if (cmd.emit_trade || cmd.emit_final)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg    <= in_data[63:0];
            price_reg <= in_data[95:64];
            qty_reg   <= in_data[127:96];
            func_reg  <= in_user[0];
            side_reg  <= in_user[1];
            mkt_reg   <= in_user[2];
        end
        if (cmd.lookup)
        begin
            left_reg <= qty_reg;
            if (func_reg == FUNC_CANCEL)
                status_reg <= hit_any ? ST_OK : ST_UNKNOWN;
            else if (hit_any)
                status_reg <= ST_DUP;
            else if (!mkt_reg && qty_reg != '0 && !free_any)
                status_reg <= ST_FULL;
            else
                status_reg <= ST_OK;
            if (func_reg == FUNC_ADD && !hit_any && !mkt_reg && qty_reg != '0 && free_any)
            begin
                sid_reg[free_idx]    <= id_reg;
                sside_reg[free_idx]  <= side_reg;
                sprice_reg[free_idx] <= price_reg;
                srem_reg[free_idx]   <= qty_reg;
                sseq_reg[free_idx]   <= arrival_reg;
            end
        end
        if (cmd.scan)
        begin
            if (c_valid && c_side == SIDE_BUY && b_better)
            begin
                bp_reg   <= c_price;
                bage_reg <= c_age;
                bi_reg   <= scan_reg;
            end
            if (c_valid && c_side == SIDE_SELL && a_better)
            begin
                ap_reg   <= c_price;
                aage_reg <= c_age;
                ai_reg   <= scan_reg;
            end
        end
        if (cmd.fill)
        begin
            left_reg          <= left_reg - ex_qty;
            srem_reg[opp_idx] <= opp_rem - ex_qty;
            tid_reg           <= sid_reg[opp_idx];
            tprice_reg        <= sprice_reg[opp_idx];
            tqty_reg          <= ex_qty;
        end
        if (cmd.emit_trade)
        begin
            okind_reg <= KIND_TRADE;
            odata_reg <= {4'b0, av_reg, (av_reg ? ap_reg : 32'd0),
                          bv_reg, (bv_reg ? bp_reg : 32'd0), 32'd0,
                          tqty_reg, tprice_reg, tid_reg, ST_OK};
        end
        else if (cmd.emit_final)
        begin
            okind_reg <= KIND_FINAL;
            odata_reg <= {4'b0, av_reg, (av_reg ? ap_reg : 32'd0),
                          bv_reg, (bv_reg ? bp_reg : 32'd0),
                          (match_reg ? left_reg : 32'd0),
                          32'd0, 32'd0, 64'd0, status_reg};
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_data    = odata_reg;
    assign out_user[0] = okind_reg;
    assign out_last    = (okind_reg == KIND_FINAL);

`ifndef SYNTHESIS
    a_fill_consumes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |=> left_reg == $past(left_reg) - $past(ex_qty) && $past(ex_qty) != '0)
        else $error("fill did not reduce the open quantity");
    a_scan_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && scan_last) |=> scan_reg == '0)
        else $error("scan index did not wrap");
    a_fill_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill |-> valid_reg[opp_idx] && sside_reg[opp_idx] != side_reg)
        else $error("fill against an invalid or same-side slot");
`endif

endmodule

>>> tb/price_time_order_book_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// price_time_order_book_test
// Self-checking test of the price-time order book. Orders are driven on
// the input stream and mirrored into a local copy of the book. The copy
// predicts every trade and completion report, and each output transaction
// is checked against the oldest pending report. Both sides stall at random.
// ----------------------------------------------------------------------------
module price_time_order_book_test;
    import ptob_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic        kind;
        logic [1:0]  status;
        logic [63:0] resting_id;
        logic [31:0] trade_price;
        logic [31:0] trade_qty;
        logic [31:0] unfilled_qty;
        logic [31:0] best_bid;
        logic        bid_valid;
        logic [31:0] best_ask;
        logic        ask_valid;
        logic        last;
    } report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [2:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    // local copy of the book
    logic        book_valid [ORDER_SLOTS];
    logic [63:0] book_id    [ORDER_SLOTS];
    logic        book_side  [ORDER_SLOTS];
    logic [31:0] book_price [ORDER_SLOTS];
    logic [31:0] book_left  [ORDER_SLOTS];
    logic [31:0] book_seq   [ORDER_SLOTS];
    logic [31:0] arrivals;

    report_t     pending_reports[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          errors = 0;
    int          trades_seen = 0;
    int          finals_seen = 0;
    int          idle_cycles = 0;
    logic [63:0] id_pool [18];

    price_time_order_book uut (.*);

    always #5 clk = ~clk;

    function automatic int find_order(logic [63:0] id);
        for (int i = 0; i < ORDER_SLOTS; i++)
            if (book_valid[i] && book_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int best_order(logic sd);
        int best;
        logic better;
        best = -1;
        for (int i = 0; i < ORDER_SLOTS; i++)
        begin
            if (!book_valid[i] || book_side[i] != sd)
                continue;
            if (best < 0)
            begin
                best = i;
                continue;
            end
            if (book_price[i] != book_price[best])
                better = sd ? (book_price[i] < book_price[best])
                            : (book_price[i] > book_price[best]);
            else
                better = 32'(arrivals - book_seq[i]) > 32'(arrivals - book_seq[best]);
            if (better)
                best = i;
        end
        return best;
    endfunction

    function automatic void add_quotes(inout report_t r);
        int b;
        int a;
        b = best_order(SIDE_BUY);
        a = best_order(SIDE_SELL);
        r.best_bid  = b >= 0 ? book_price[b] : 32'd0;
        r.bid_valid = b >= 0;
        r.best_ask  = a >= 0 ? book_price[a] : 32'd0;
        r.ask_valid = a >= 0;
    endfunction

    function automatic void push_completion(status_t st, logic [31:0] unfilled);
        report_t r;
        r = '{default: '0};
        r.kind = KIND_FINAL;
        r.status = st;
        r.unfilled_qty = unfilled;
        r.last = 1'b1;
        add_quotes(r);
        pending_reports.insert(pending_reports.size(), r);
    endfunction

    function automatic void predict_order(logic func, logic [63:0] id, logic sd,
                                          logic mkt, logic [31:0] price,
                                          logic [31:0] qty);
        int s;
        int fills;
        logic [31:0] left;
        logic [31:0] ex;
        report_t r;
        if (func == FUNC_CANCEL)
        begin
            s = find_order(id);
            if (s < 0)
                push_completion(ST_UNKNOWN, 0);
            else
            begin
                book_valid[s] = 1'b0;
                push_completion(ST_OK, 0);
            end
            return;
        end
        if (find_order(id) >= 0)
        begin
            push_completion(ST_DUP, 0);
            return;
        end
        if (!mkt)
        begin
            if (qty != 0)
            begin
                s = -1;
                for (int i = 0; i < ORDER_SLOTS; i++)
                    if (!book_valid[i] && s < 0)
                        s = i;
                if (s < 0)
                begin
                    push_completion(ST_FULL, 0);
                    return;
                end
                book_valid[s] = 1'b1;
                book_id[s] = id;
                book_side[s] = sd;
                book_price[s] = price;
                book_left[s] = qty;
                book_seq[s] = arrivals;
                arrivals = arrivals + 1;
            end
            push_completion(ST_OK, 0);
            return;
        end
        left = qty;
        fills = 0;
        while (left > 0 && fills < MAX_FILLS)
        begin
            s = best_order(~sd);
            if (s < 0)
                break;
            ex = left < book_left[s] ? left : book_left[s];
            left = left - ex;
            book_left[s] = book_left[s] - ex;
            if (book_left[s] == 0)
                book_valid[s] = 1'b0;
            r = '{default: '0};
            r.kind = KIND_TRADE;
            r.status = ST_OK;
            r.resting_id = book_id[s];
            r.trade_price = book_price[s];
            r.trade_qty = ex;
            add_quotes(r);
            pending_reports.insert(pending_reports.size(), r);
            fills++;
        end
        push_completion(ST_OK, left);
    endfunction

    function automatic int resting_count();
        int n;
        n = 0;
        for (int i = 0; i < ORDER_SLOTS; i++)
            n += book_valid[i];
        return n;
    endfunction

    task automatic send_order(logic func, logic [63:0] id, logic sd, logic mkt,
                              logic [31:0] price, logic [31:0] qty);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {qty, price, id};
        s_tuser  <= {mkt, sd, func};
        do
            @(posedge clk);
        while (!s_tready);
        predict_order(func, id, sd, mkt, price, qty);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending_reports.size() == 0);
        repeat (80) @(posedge clk);
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        report_t e;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (m_tuser[0] == KIND_TRADE)
                trades_seen++;
            else
                finals_seen++;
            if (pending_reports.size() == 0)
            begin
                $error("unexpected output transaction");
                errors++;
            end
            else
            begin
                e = pending_reports.pop_front();
                if (m_tuser[0] !== e.kind)
                begin
                    $error("kind: expected %0d actual %0d", e.kind, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[1:0] !== e.status)
                begin
                    $error("status: expected %0d actual %0d", e.status, m_tdata[1:0]);
                    errors++;
                end
                if (m_tdata[65:2] !== e.resting_id)
                begin
                    $error("resting_id: expected %h actual %h", e.resting_id, m_tdata[65:2]);
                    errors++;
                end
                if (m_tdata[97:66] !== e.trade_price)
                begin
                    $error("trade_price: expected %h actual %h", e.trade_price,
                           m_tdata[97:66]);
                    errors++;
                end
                if (m_tdata[129:98] !== e.trade_qty)
                begin
                    $error("trade_qty: expected %h actual %h", e.trade_qty, m_tdata[129:98]);
                    errors++;
                end
                if (m_tdata[161:130] !== e.unfilled_qty)
                begin
                    $error("unfilled_qty: expected %h actual %h", e.unfilled_qty,
                           m_tdata[161:130]);
                    errors++;
                end
                if (m_tdata[193:162] !== e.best_bid)
                begin
                    $error("best_bid: expected %h actual %h", e.best_bid, m_tdata[193:162]);
                    errors++;
                end
                if (m_tdata[194] !== e.bid_valid)
                begin
                    $error("bid_valid: expected %0d actual %0d", e.bid_valid, m_tdata[194]);
                    errors++;
                end
                if (m_tdata[226:195] !== e.best_ask)
                begin
                    $error("best_ask: expected %h actual %h", e.best_ask, m_tdata[226:195]);
                    errors++;
                end
                if (m_tdata[227] !== e.ask_valid)
                begin
                    $error("ask_valid: expected %0d actual %0d", e.ask_valid, m_tdata[227]);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last: expected %0d actual %0d", e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_order(FUNC_CANCEL, id_pool[0], SIDE_BUY, 1'b0, 0, 0);
        send_order(FUNC_ADD, id_pool[1], SIDE_BUY, 1'b1, 0, 32'hFFFF_FFFF);
        send_order(FUNC_ADD, id_pool[0], SIDE_BUY, 1'b0, 32'd0, 32'd5);
        send_order(FUNC_ADD, id_pool[1], SIDE_BUY, 1'b0, 32'd100, 32'd7);
        send_order(FUNC_ADD, id_pool[2], SIDE_BUY, 1'b0, 32'd100, 32'd3);
        send_order(FUNC_ADD, id_pool[3], SIDE_SELL, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_order(FUNC_ADD, id_pool[4], SIDE_SELL, 1'b0, 32'd200, 32'd4);
        send_order(FUNC_ADD, id_pool[4], SIDE_SELL, 1'b1, 32'd0, 32'd1);
        send_order(FUNC_ADD, id_pool[5], SIDE_SELL, 1'b0, 32'd150, 32'd0);
        send_order(FUNC_ADD, id_pool[5], SIDE_SELL, 1'b1, 32'd0, 32'd0);
        send_order(FUNC_ADD, id_pool[6], SIDE_SELL, 1'b1, 32'hFFFF_FFFF, 32'd9);
        send_order(FUNC_ADD, id_pool[7], SIDE_BUY, 1'b1, 32'd1, 32'd6);
        send_order(FUNC_CANCEL, id_pool[3], SIDE_SELL, 1'b1, 32'hFFFF_FFFF, 32'd1);
        send_order(FUNC_CANCEL, id_pool[3], SIDE_BUY, 1'b0, 32'd0, 32'd0);
        send_order(FUNC_ADD, id_pool[8], SIDE_SELL, 1'b1, 32'd0, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_book_full();
        int n;
        n = 0;
        while (resting_count() < ORDER_SLOTS)
        begin
            send_order(FUNC_ADD, {$urandom, $urandom} | 64'h1, n[0], 1'b0,
                       32'd1000 + $urandom_range(3), $urandom_range(1, 9));
            n++;
        end
        send_order(FUNC_ADD, {$urandom, $urandom}, SIDE_BUY, 1'b0, 32'd5, 32'd5);
        send_order(FUNC_ADD, id_pool[9], SIDE_SELL, 1'b1, 32'd0, 32'hFFFF_FFFF);
        send_order(FUNC_ADD, id_pool[10], SIDE_BUY, 1'b1, 32'd0, 32'hFFFF_FFFF);
        while (resting_count() < ORDER_SLOTS)
            send_order(FUNC_ADD, {$urandom, $urandom}, SIDE_SELL, 1'b0,
                       32'd50 + $urandom_range(1), $urandom_range(1, 3));
        send_order(FUNC_ADD, id_pool[11], SIDE_BUY, 1'b1, 32'd0, 32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_random(int count);
        logic [63:0] id;
        logic [31:0] price;
        logic [31:0] qty;
        logic        mkt;
        int          r;
        for (int k = 0; k < count; k++)
        begin
            id = id_pool[$urandom_range(17)];
            if ($urandom_range(9) == 0)
                id = {$urandom, $urandom};
            r = $urandom_range(99);
            price = ($urandom_range(9) == 0) ? $urandom
                                             : 32'h8000_0000 + $urandom_range(7);
            qty = $urandom_range(1, 40);
            if (r < 25)
            begin
                send_order(FUNC_CANCEL, id, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           $urandom, $urandom);
                continue;
            end
            mkt = r >= 80;
            if (mkt)
                qty = $urandom_range(1, 150);
            r = $urandom_range(19);
            if (r == 0)
                qty = 0;
            else if (r == 1)
                qty = $urandom;
            send_order(FUNC_ADD, id, 1'($urandom_range(1)), mkt, price, qty);
        end
        drain();
    endtask

    initial
    begin
        for (int i = 0; i < ORDER_SLOTS; i++)
            book_valid[i] = 1'b0;
        arrivals = 0;
        id_pool[16] = 64'd0;
        id_pool[17] = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < 16; i++)
            id_pool[i] = {$urandom, $urandom};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 59;
        test_directed();
        test_book_full();
        test_random(60);
        send_idle_pct = 59;
        recv_idle_pct = 24;
        test_random(60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(60);

        $display("Covered directed cases, a full book with sweeping market orders");
        $display("and random order flow: %0d trade and %0d completion reports",
                 trades_seen, finals_seen);
        if (errors == 0 && pending_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
